>>> rtl/tarag_pkg.sv
// Package with the types and constants of the rolled-axis tensor address generator.
package tarag_pkg;

    localparam int OFFSET_W   = 48;
    localparam int INDEX_W    = 12;
    localparam int SIZE_W     = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int SIZE_REGS  = 4;
    localparam logic [SIZE_W-1:0] MAX_SIZE = 13'd4096;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_DIMS      = 3'd0,
        CFG_SOURCE_AXIS   = 3'd1,
        CFG_DEST_POSITION = 3'd2,
        CFG_DIM_SIZE_0    = 3'd3,
        CFG_DIM_SIZE_1    = 3'd4,
        CFG_DIM_SIZE_2    = 3'd5,
        CFG_DIM_SIZE_3    = 3'd6
    } t_cfg_index;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_STRIDE,
        SEQ_TERM
    } t_seq_state;

    typedef struct packed {
        logic [OFFSET_W-1:0] source_offset;
        logic [OFFSET_W-1:0] result_offset;
        logic                last_element;
        logic                axis_error;
    } t_result;

    function automatic logic [SIZE_W-1:0] size_clamp(input logic [SIZE_W-1:0] s);
        logic [SIZE_W-1:0] r;
        r = s;
        if (s == '0) begin
            r = SIZE_W'(1);
        end else if (s > MAX_SIZE) begin
            r = MAX_SIZE;
        end
        return r;
    endfunction

endpackage

>>> rtl/tensor_axis_roll_address_gen.sv
// Top level of the rolled-axis tensor address generator.
// A result is registered when its input transaction is accepted.
// Throughput: one transaction per cycle unless setup or a full skid register stalls the input;
// a skid register takes one more while the output stalls. After reset and after every configuration
// write, a setup pass computes strides, then wrap terms and offset deltas, with two narrow multipliers.
// Reset is synchronous and active low; it loads the register defaults and restarts the walk.
module tensor_axis_roll_address_gen
    import tarag_pkg::*;
#(
    parameter int MAX_DIMS = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_restart,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [OFFSET_W-1:0]   o_source_offset,
    output logic [OFFSET_W-1:0]   o_result_offset,
    output logic                  o_last_element,
    output logic                  o_axis_error
);

    localparam int IW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

    logic [2:0]              r_num_dims;
    logic signed [2:0]       r_src_axis;
    logic signed [3:0]       r_dest_pos;
    logic [SIZE_W-1:0]       r_dim [SIZE_REGS];

    t_seq_state              r_state, n_state;
    logic [IW-1:0]           r_cnt;
    logic [OFFSET_W-1:0]     r_run;
    logic [OFFSET_W-1:0]     r_stride [MAX_DIMS];
    logic [OFFSET_W-1:0]     r_delta [MAX_DIMS];
    logic [INDEX_W-1:0]      r_rmax [MAX_DIMS];
    logic [OFFSET_W-1:0]     r_prod;
    logic [OFFSET_W-1:0]     r_spd;
    logic [IW-1:0]           r_cd;
    logic                    r_pv;
    logic [OFFSET_W-1:0]     r_acc;
    logic                    busy;

    logic [INDEX_W-1:0]      r_idx [MAX_DIMS];
    logic [OFFSET_W-1:0]     r_src;
    logic [OFFSET_W-1:0]     r_flat;

    t_result                 r_out, r_skid, n_res;
    logic                    r_out_valid, r_skid_valid;

    logic                    cfg_write;
    logic                    in_accept;
    logic                    out_take;

    logic signed [4:0]       n5, ax5, st5, ax_n, st_n, st_a, c5, perm_c5;
    logic                    scalar, axis_err;
    logic [IW-1:0]           perm_c, seq_addr;
    logic [SIZE_W-1:0]       size_a;
    logic [OFFSET_W-1:0]     stride_a;
    logic [INDEX_W-1:0]      rm;

    logic [INDEX_W-1:0]      cur_idx [MAX_DIMS];
    logic [INDEX_W-1:0]      n_idx [MAX_DIMS];
    logic [OFFSET_W-1:0]     cur_src, cur_flat, n_src, n_flat;
    logic [IW-1:0]           jsel;
    logic                    last;

    assign cfg_write = i_cfg_we && (i_cfg_index <= CFG_DIM_SIZE_3);
    assign o_in_stall = r_skid_valid || busy;
    assign in_accept = i_in_valid && !o_in_stall;
    assign out_take = r_out_valid && !i_out_stall;

    // Axis normalization and error checks.
    always_comb begin
        n5   = signed'({2'b00, r_num_dims});
        ax5  = {{2{r_src_axis[2]}}, r_src_axis};
        st5  = {r_dest_pos[3], r_dest_pos};
        ax_n = (ax5 < 0) ? ax5 + n5 : ax5;
        st_n = (st5 < 0) ? st5 + n5 : st5;
        scalar = (r_num_dims == 3'd0);
        axis_err = !scalar && ((int'(r_num_dims) > MAX_DIMS) || (ax_n < 0) || (ax_n >= n5)
                   || (st_n < 0) || (st_n > n5));
        st_a = (ax_n < st_n) ? st_n - 5'sd1 : st_n;
    end

    // Source axis read by result axis r_cnt.
    always_comb begin
        c5 = signed'(5'(r_cnt));
        if (axis_err || scalar || (c5 >= n5)) begin
            perm_c5 = c5;
        end else if (c5 < st_a) begin
            perm_c5 = (c5 < ax_n) ? c5 : c5 + 5'sd1;
        end else if (c5 == st_a) begin
            perm_c5 = ax_n;
        end else begin
            perm_c5 = (c5 - 5'sd1 < ax_n) ? c5 - 5'sd1 : c5;
        end
        perm_c = IW'(perm_c5);
        seq_addr = (r_state == SEQ_STRIDE) ? r_cnt : perm_c;
        if ((int'(seq_addr) < SIZE_REGS) && (int'(seq_addr) < int'(r_num_dims))) begin
            size_a = size_clamp(r_dim[2'(seq_addr)]);
        end else begin
            size_a = SIZE_W'(1);
        end
        stride_a = r_stride[seq_addr];
        rm = (c5 < n5) ? INDEX_W'(size_a - SIZE_W'(1)) : '0;
    end

    always_comb begin
        n_state = r_state;
        busy = r_pv;
        case (r_state)
            SEQ_IDLE: begin
            end
            SEQ_STRIDE: begin
                busy = 1'b1;
                if (r_cnt == '0) begin
                    n_state = SEQ_TERM;
                end
            end
            SEQ_TERM: begin
                busy = 1'b1;
                if (r_cnt == '0) begin
                    n_state = SEQ_IDLE;
                end
            end
            default: begin
                n_state = SEQ_IDLE;
            end
        endcase
        if (cfg_write) begin
            n_state = SEQ_STRIDE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SEQ_STRIDE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_dims <= 3'd1;
            r_src_axis <= '0;
            r_dest_pos <= '0;
            for (int i = 0; i < SIZE_REGS; i++) begin
                r_dim[i] <= SIZE_W'(1);
            end
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_NUM_DIMS:      r_num_dims <= i_cfg_data[2:0];
                CFG_SOURCE_AXIS:   r_src_axis <= i_cfg_data[2:0];
                CFG_DEST_POSITION: r_dest_pos <= i_cfg_data[3:0];
                CFG_DIM_SIZE_0:    r_dim[0] <= i_cfg_data;
                CFG_DIM_SIZE_1:    r_dim[1] <= i_cfg_data;
                CFG_DIM_SIZE_2:    r_dim[2] <= i_cfg_data;
                CFG_DIM_SIZE_3:    r_dim[3] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= (r_state == SEQ_TERM) && !cfg_write;
        end
    end

    // Setup datapath: strides per source axis from the last down, then per result axis the wrap term and delta.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_write) begin
            r_cnt <= IW'(MAX_DIMS - 1);
            r_run <= OFFSET_W'(1);
        end else begin
            case (r_state)
                SEQ_STRIDE: begin
                    r_stride[r_cnt] <= r_run;
                    r_run <= OFFSET_W'(r_run * size_a);
                    r_acc <= '0;
                    r_cnt <= (r_cnt == '0) ? IW'(MAX_DIMS - 1) : r_cnt - IW'(1);
                end
                SEQ_TERM: begin
                    r_rmax[r_cnt] <= rm;
                    r_prod <= OFFSET_W'(rm * stride_a);
                    r_spd <= stride_a;
                    r_cd <= r_cnt;
                    r_cnt <= (r_cnt == '0) ? IW'(MAX_DIMS - 1) : r_cnt - IW'(1);
                end
                default: begin
                end
            endcase
            if (r_pv) begin
                r_delta[r_cd] <= r_spd - r_acc;
                r_acc <= r_acc + r_prod;
            end
        end
    end

    // Walk step for one transaction.
    always_comb begin
        for (int r = 0; r < MAX_DIMS; r++) begin
            cur_idx[r] = i_restart ? '0 : r_idx[r];
        end
        cur_src  = i_restart ? '0 : r_src;
        cur_flat = i_restart ? '0 : r_flat;
        last = 1'b1;
        jsel = '0;
        for (int r = 0; r < MAX_DIMS; r++) begin
            if (cur_idx[r] != r_rmax[r]) begin
                last = 1'b0;
                jsel = IW'(r);
            end
        end
        for (int r = 0; r < MAX_DIMS; r++) begin
            if (scalar || axis_err) begin
                n_idx[r] = cur_idx[r];
            end else if (last || (r > int'(jsel))) begin
                n_idx[r] = '0;
            end else if (r == int'(jsel)) begin
                n_idx[r] = cur_idx[r] + INDEX_W'(1);
            end else begin
                n_idx[r] = cur_idx[r];
            end
        end
        if (scalar || axis_err) begin
            n_src  = cur_src;
            n_flat = cur_flat;
        end else if (last) begin
            n_src  = '0;
            n_flat = '0;
        end else begin
            n_src  = cur_src + r_delta[jsel];
            n_flat = cur_flat + OFFSET_W'(1);
        end
        n_res = '0;
        if (scalar) begin
            n_res.last_element = 1'b1;
        end else if (axis_err) begin
            n_res.axis_error = 1'b1;
        end else begin
            n_res.source_offset = cur_src;
            n_res.result_offset = cur_flat;
            n_res.last_element  = last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_write) begin
            for (int r = 0; r < MAX_DIMS; r++) begin
                r_idx[r] <= '0;
            end
            r_src  <= '0;
            r_flat <= '0;
        end else if (in_accept) begin
            r_idx  <= n_idx;
            r_src  <= n_src;
            r_flat <= n_flat;
        end
    end

    // Output register with a skid register behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_take) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= in_accept;
            end
        end else if (in_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_take) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_accept) begin
                r_out <= n_res;
            end
        end else if (in_accept) begin
            r_skid <= n_res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_source_offset = r_out.source_offset;
    assign o_result_offset = r_out.result_offset;
    assign o_last_element  = r_out.last_element;
    assign o_axis_error    = r_out.axis_error;

endmodule

>>> rtl/tarag_checker.sv
// Port-level assertion checker for the rolled-axis tensor address generator, with its bind.
module tarag_checker
    import tarag_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_cfg_we,
    input logic [CFG_IDX_W-1:0]  i_cfg_index,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input logic                  i_restart,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input logic [OFFSET_W-1:0]   o_source_offset,
    input logic [OFFSET_W-1:0]   o_result_offset,
    input logic                  o_last_element,
    input logic                  o_axis_error
);

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_axis_error) |->
        (o_source_offset == '0 && o_result_offset == '0 && !o_last_element))
        else $error("Axis error transaction carries nonzero offsets or last flag.");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
        (o_out_valid && $stable(o_source_offset) && $stable(o_result_offset)))
        else $error("Stalled output transaction changed.");

    a_cfg_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && i_cfg_index <= CFG_DIM_SIZE_3) |=> o_in_stall)
        else $error("Input not stalled during setup after a configuration write.");

    a_restart_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && !o_out_valid && i_restart) |=>
        (o_out_valid && o_result_offset == '0 && o_source_offset == '0))
        else $error("Restarted walk did not begin at element zero.");

endmodule

bind tensor_axis_roll_address_gen tarag_checker u_tarag_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_cfg_we        (i_cfg_we),
    .i_cfg_index     (i_cfg_index),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .i_restart       (i_restart),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_source_offset (o_source_offset),
    .o_result_offset (o_result_offset),
    .o_last_element  (o_last_element),
    .o_axis_error    (o_axis_error)
);

>>> bench/testbench.sv
// Testbench for the rolled-axis tensor address generator, checked against a built-in walk predictor.
`timescale 1ns / 100ps

module testbench;
    import tarag_pkg::*;

    localparam int IDLE_LIMIT = 4000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  i_restart = 1'b0;
    logic                  i_out_stall = 1'b0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    logic [OFFSET_W-1:0]   o_source_offset;
    logic [OFFSET_W-1:0]   o_result_offset;
    logic                  o_last_element;
    logic                  o_axis_error;

    logic [2:0]          rank_reg;
    logic [2:0]          axis_reg;
    logic [3:0]          position_reg;
    logic [SIZE_W-1:0]   size_reg [SIZE_REGS];
    logic [INDEX_W-1:0]  walk_index [4];
    logic [OFFSET_W-1:0] walk_flat;

    t_result expected_offsets [$];
    t_result oldest_expected;
    int      mismatch_count = 0;
    int      idle_cycles = 0;
    int      send_gap_pct = 0;
    int      recv_stall_pct = 0;
    int      out_hold_left = 0;

    tensor_axis_roll_address_gen DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_restart       (i_restart),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_source_offset (o_source_offset),
        .o_result_offset (o_result_offset),
        .o_last_element  (o_last_element),
        .o_axis_error    (o_axis_error)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic void clear_walk();
        for (int i = 0; i < 4; i++) begin
            walk_index[i] = '0;
        end
        walk_flat = '0;
    endfunction

    function automatic void apply_register_write(input t_cfg_index idx,
                                                 input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_NUM_DIMS: begin
                rank_reg = data[2:0];
            end
            CFG_SOURCE_AXIS: begin
                axis_reg = data[2:0];
            end
            CFG_DEST_POSITION: begin
                position_reg = data[3:0];
            end
            default: begin
                size_reg[int'(idx) - int'(CFG_DIM_SIZE_0)] = data;
            end
        endcase
        clear_walk();
    endfunction

    function automatic t_result predict_rolled_offsets(input logic restart);
        t_result         r;
        int              n;
        int              ax;
        int              st;
        int              k;
        int              perm [4];
        longint unsigned src_size [4];
        longint unsigned src_stride [4];
        longint unsigned res_size [4];
        longint unsigned src_off;
        bit              last;
        r = '0;
        src_off = 0;
        last = 1'b1;
        if (restart) begin
            clear_walk();
        end
        n = rank_reg;
        if (n == 0) begin
            r.last_element = 1'b1;
            return r;
        end
        ax = $signed(axis_reg);
        st = $signed(position_reg);
        if (ax < 0) begin
            ax += n;
        end
        if (st < 0) begin
            st += n;
        end
        if (n > 4 || ax < 0 || ax >= n || st < 0 || st > n) begin
            r.axis_error = 1'b1;
            return r;
        end
        if (ax < st) begin
            st--;
        end
        for (int i = 0; i < n; i++) begin
            if (size_reg[i] == 0) begin
                src_size[i] = 1;
            end else if (size_reg[i] > 4096) begin
                src_size[i] = 4096;
            end else begin
                src_size[i] = size_reg[i];
            end
        end
        src_stride[n-1] = 1;
        for (int i = n - 2; i >= 0; i--) begin
            src_stride[i] = src_stride[i+1] * src_size[i+1];
        end
        k = 0;
        for (int i = 0; i < n; i++) begin
            if (k == st) begin
                k++;
            end
            if (i != ax) begin
                perm[k] = i;
                k++;
            end
        end
        perm[st] = ax;
        for (int i = 0; i < n; i++) begin
            res_size[i] = src_size[perm[i]];
            src_off += longint'(walk_index[i]) * src_stride[perm[i]];
            if (longint'(walk_index[i]) + 1 < res_size[i]) begin
                last = 1'b0;
            end
        end
        r.source_offset = src_off[OFFSET_W-1:0];
        r.result_offset = walk_flat;
        r.last_element = last;
        if (last) begin
            clear_walk();
        end else begin
            for (int i = n - 1; i >= 0; i--) begin
                if (longint'(walk_index[i]) + 1 < res_size[i]) begin
                    walk_index[i] = walk_index[i] + 1'b1;
                    break;
                end
                walk_index[i] = '0;
            end
            walk_flat = walk_flat + 1'b1;
        end
        return r;
    endfunction

    always @(negedge i_clk) begin
        if (out_hold_left > 0) begin
            i_out_stall <= 1'b1;
            out_hold_left = out_hold_left - 1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_offsets.size() == 0) begin
                $display("%0t: result transaction with none expected: src %h res %h",
                         $time, o_source_offset, o_result_offset);
                mismatch_count++;
            end else begin
                oldest_expected = expected_offsets.pop_front();
                if (o_source_offset !== oldest_expected.source_offset) begin
                    $display("%0t: source_offset expected %h actual %h", $time,
                             oldest_expected.source_offset, o_source_offset);
                    mismatch_count++;
                end
                if (o_result_offset !== oldest_expected.result_offset) begin
                    $display("%0t: result_offset expected %h actual %h", $time,
                             oldest_expected.result_offset, o_result_offset);
                    mismatch_count++;
                end
                if (o_last_element !== oldest_expected.last_element) begin
                    $display("%0t: last_element expected %b actual %b", $time,
                             oldest_expected.last_element, o_last_element);
                    mismatch_count++;
                end
                if (o_axis_error !== oldest_expected.axis_error) begin
                    $display("%0t: axis_error expected %b actual %b", $time,
                             oldest_expected.axis_error, o_axis_error);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_in_valid && !o_in_stall)
                || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("FAIL tensor_axis_roll_address_gen");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_item(input logic restart);
        while ($urandom_range(99) < send_gap_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_restart <= restart;
        do @(posedge i_clk); while (o_in_stall);
        expected_offsets.push_back(predict_rolled_offsets(restart));
    endtask

    task automatic wait_for_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_offsets.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_register(input t_cfg_index idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        apply_register_write(idx, data);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] rank, input logic [CFG_DATA_W-1:0] axis,
                             input logic [CFG_DATA_W-1:0] position,
                             input logic [CFG_DATA_W-1:0] s0, input logic [CFG_DATA_W-1:0] s1,
                             input logic [CFG_DATA_W-1:0] s2, input logic [CFG_DATA_W-1:0] s3);
        wait_for_results();
        write_register(CFG_NUM_DIMS, rank);
        write_register(CFG_SOURCE_AXIS, axis);
        write_register(CFG_DEST_POSITION, position);
        write_register(CFG_DIM_SIZE_0, s0);
        write_register(CFG_DIM_SIZE_1, s1);
        write_register(CFG_DIM_SIZE_2, s2);
        write_register(CFG_DIM_SIZE_3, s3);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic test_reset_defaults();
        send_item(1'b0);
        send_item(1'b1);
        send_item(1'b0);
    endtask

    task automatic test_scalar_and_bad_axes();
        configure(0, 5, 7, 3, 2, 1, 1);
        send_item(1'b0);
        send_item(1'b1);
        configure(2, 2, 0, 2, 3, 1, 1);
        send_item(1'b0);
        configure(2, 0, 12, 2, 3, 1, 1);
        send_item(1'b0);
        configure(2, 0, 3, 2, 3, 1, 1);
        send_item(1'b0);
        configure(5, 0, 0, 2, 2, 2, 2);
        send_item(1'b0);
        configure(7, 4, 8, 2, 2, 2, 2);
        send_item(1'b1);
        configure(4, 4, 8, 2, 2, 2, 2);
        send_item(1'b0);
        configure(3, 7, 13, 2, 3, 2, 1);
        send_item(1'b0);
        send_item(1'b0);
    endtask

    task automatic test_clamped_sizes();
        configure(4, 7, 4, 0, 8191, 4096, 2);
        repeat (4) send_item(1'b0);
        configure(2, 1, 0, 4097, 0, 1, 1);
        repeat (3) send_item(1'b0);
    endtask

    task automatic test_wide_offsets();
        configure(4, 0, 4, 4096, 4096, 4096, 4096);
        repeat (4) send_item(1'b0);
    endtask

    task automatic test_output_holdoff();
        send_gap_pct = 0;
        recv_stall_pct = 0;
        wait_for_results();
        @(posedge i_clk);
        out_hold_left = 60;
        repeat (20) send_item(1'b0);
        wait_for_results();
    endtask

    task automatic load_random_configuration();
        int kind;
        int n;
        int ax;
        int st;
        logic [CFG_DATA_W-1:0] sizes [4];
        kind = $urandom_range(99);
        n = $urandom_range(1, 4);
        ax = $urandom_range(0, n - 1);
        st = $urandom_range(0, n);
        if ($urandom_range(1)) begin
            ax -= n;
        end
        if ($urandom_range(1)) begin
            st -= n;
        end
        for (int i = 0; i < 4; i++) begin
            case ($urandom_range(4))
                0: sizes[i] = 0;
                1: sizes[i] = 4096;
                2: sizes[i] = CFG_DATA_W'($urandom_range(4097, 8191));
                default: sizes[i] = CFG_DATA_W'($urandom_range(1, 4096));
            endcase
            if (kind >= 30) begin
                sizes[i] = CFG_DATA_W'($urandom_range(0, 4));
            end
        end
        if (kind < 10) begin
            configure(CFG_DATA_W'($urandom) & 13'h1FF8, CFG_DATA_W'($urandom),
                      CFG_DATA_W'($urandom), sizes[0], sizes[1], sizes[2], sizes[3]);
        end else if (kind < 20) begin
            configure(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                      CFG_DATA_W'($urandom), sizes[0], sizes[1], sizes[2], sizes[3]);
        end else begin
            configure((CFG_DATA_W'($urandom) & 13'h1FF8) | CFG_DATA_W'(n),
                      (CFG_DATA_W'($urandom) & 13'h1FF8) | CFG_DATA_W'(ax & 7),
                      (CFG_DATA_W'($urandom) & 13'h1FF0) | CFG_DATA_W'(st & 15),
                      sizes[0], sizes[1], sizes[2], sizes[3]);
        end
    endtask

    task automatic rewrite_one_register();
        t_cfg_index idx;
        logic [CFG_DATA_W-1:0] data;
        idx = t_cfg_index'($urandom_range(0, 6));
        case (idx)
            CFG_NUM_DIMS:      data = CFG_DATA_W'(rank_reg);
            CFG_SOURCE_AXIS:   data = CFG_DATA_W'(axis_reg);
            CFG_DEST_POSITION: data = CFG_DATA_W'(position_reg);
            default:           data = size_reg[int'(idx) - int'(CFG_DIM_SIZE_0)];
        endcase
        wait_for_results();
        write_register(idx, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic test_random_walks(input int gap_pct, input int stall_pct, input int items);
        int sent;
        int walk_len;
        sent = 0;
        send_gap_pct = gap_pct;
        recv_stall_pct = stall_pct;
        while (sent < items) begin
            if ($urandom_range(99) < 15) begin
                rewrite_one_register();
            end else begin
                load_random_configuration();
            end
            walk_len = $urandom_range(8, 60);
            for (int i = 0; i < walk_len; i++) begin
                if (i == walk_len / 2 && $urandom_range(99) < 10) begin
                    wait_for_results();
                end
                send_item($urandom_range(99) < 6);
            end
            sent += walk_len;
        end
    endtask

    initial begin
        rank_reg = 3'd1;
        axis_reg = '0;
        position_reg = '0;
        for (int i = 0; i < SIZE_REGS; i++) begin
            size_reg[i] = 1;
        end
        clear_walk();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_scalar_and_bad_axes();
        test_clamped_sizes();
        test_wide_offsets();
        test_output_holdoff();
        test_random_walks(0, 0, 300);
        test_random_walks(81, 0, 300);
        test_random_walks(0, 81, 300);
        test_random_walks(14, 14, 300);
        test_output_holdoff();

        wait_for_results();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && expected_offsets.size() == 0) begin
            $display("PASS tensor_axis_roll_address_gen");
        end else begin
            $display("FAIL tensor_axis_roll_address_gen");
        end
        $finish;
    end

endmodule

>>> tensor_axis_roll_address_gen.f
rtl/tarag_pkg.sv
rtl/tensor_axis_roll_address_gen.sv
rtl/tarag_checker.sv
bench/testbench.sv
